// ===== hdl/tapfc_pkg.sv =====
// Package for the two-axis PI controller with feedforward.
// Holds widths, register reset values, register indexes, sequencer states and saturation helpers.
// No dependencies; imported by two_axis_pi_feedforward_controller, pi_tick_check_pkg and tb_top.
package tapfc_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int NUM_FIELDS = 6;
	localparam int TDATA_W    = NUM_FIELDS * DATA_WIDTH;
	localparam int CFG_AW     = 3;
	// signed operand (DATA_WIDTH+1 bits) times unsigned made signed (DATA_WIDTH+1 bits)
	localparam int PROD_W     = 2 * (DATA_WIDTH + 1);

	localparam logic [DATA_WIDTH-1:0] GAIN_RST  = DATA_WIDTH'(65536);
	localparam logic [DATA_WIDTH-1:0] INV_RST   = '0;
	localparam logic [DATA_WIDTH-1:0] TS_RST    = DATA_WIDTH'(655);
	localparam logic signed [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	typedef enum logic [CFG_AW-1:0] {
		CFG_GAIN_X  = 3'd0,
		CFG_GAIN_Y  = 3'd1,
		CFG_INV_TI_X = 3'd2,
		CFG_INV_TI_Y = 3'd3,
		CFG_SAMPLE_TIME = 3'd4
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_MUL_I,
		ST_SUM,
		ST_MUL_P,
		ST_VEL,
		ST_MUL_T,
		ST_ACC,
		ST_OUT
	} state_t;

	// saturate a sum that is one bit wider than the data path
	function automatic logic signed [DATA_WIDTH-1:0] sat_sum(
		input logic signed [DATA_WIDTH:0] v
	);
		logic signed [DATA_WIDTH-1:0] r;
		if (v[DATA_WIDTH] != v[DATA_WIDTH-1])
			r = v[DATA_WIDTH] ? SMIN : SMAX;
		else
			r = v[DATA_WIDTH-1:0];
		return r;
	endfunction

	// shift a full product right by FRAC_BITS (floor) and saturate
	function automatic logic signed [DATA_WIDTH-1:0] sat_prod(
		input logic signed [PROD_W-1:0] p
	);
		logic [PROD_W-FRAC_BITS-DATA_WIDTH:0] top;
		logic signed [DATA_WIDTH-1:0] r;
		top = p[PROD_W-1:FRAC_BITS+DATA_WIDTH-1];
		if ((top != '0) && (top != '1))
			r = p[PROD_W-1] ? SMIN : SMAX;
		else
			r = p[FRAC_BITS+DATA_WIDTH-1:FRAC_BITS];
		return r;
	endfunction

endpackage

// ===== hdl/two_axis_pi_feedforward_controller.sv =====
// Two-axis PI position controller with velocity feedforward, fixed point.
// An accepted request steps x then y through the sequencer, then ST_OUT loads the output.
// One shared multiplier and one shared saturating adder run 7 steps per axis (14 steps).
// A new request is taken only in idle, after the output load, which waits for the old result to go.
// Reset (arst_n low, async): integrals cleared, gains 1.0, 1/Ti 0, Ts 655; no output pending.
// Input is taken again while a finished result still waits in the output register.
module two_axis_pi_feedforward_controller import tapfc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_AW-1:0]     cfg_addr,
	input  logic [DATA_WIDTH-1:0] cfg_data,
	// input requests
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [TDATA_W-1:0]    s_axis_tdata,  // ref_x, ref_y, pos_x, pos_y, ff_x, ff_y
	// result requests
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [TDATA_W-1:0]    m_axis_tdata   // vel_x, vel_y, err_x, err_y,
	                                             // int_x_out, int_y_out
);

	// configuration registers
	logic [DATA_WIDTH-1:0] gain_q [2];
	logic [DATA_WIDTH-1:0] inv_ti_q [2];
	logic [DATA_WIDTH-1:0] ts_q;

	// captured request fields, index 0 = x, 1 = y
	logic signed [DATA_WIDTH-1:0] ref_q [2];
	logic signed [DATA_WIDTH-1:0] pos_q [2];
	logic signed [DATA_WIDTH-1:0] ff_q [2];

	// per-axis working values and integral state
	logic signed [DATA_WIDTH-1:0] acc_q [2];
	logic signed [DATA_WIDTH-1:0] err_q [2];
	logic signed [DATA_WIDTH-1:0] sum_q;
	logic signed [DATA_WIDTH-1:0] vel_q [2];

	logic signed [PROD_W-1:0] prod_q;

	state_t state_q, state_d;
	logic   ax_q;
	logic   out_valid_q;
	logic [TDATA_W-1:0] out_data_q;

	// shared arithmetic operands
	logic signed [DATA_WIDTH-1:0] add_a, add_b;
	logic                         add_sub;
	logic signed [DATA_WIDTH:0]   add_wide;
	logic signed [DATA_WIDTH-1:0] add_res;
	logic signed [DATA_WIDTH-1:0] mul_a;
	logic [DATA_WIDTH-1:0]        mul_b;
	logic signed [PROD_W-1:0]     mul_res;
	logic signed [DATA_WIDTH-1:0] prod_sat;
	logic                         load_out;

	assign prod_sat = sat_prod(prod_q);

	// sequencer: next state and operand selection
	always_comb begin
		state_d  = state_q;
		add_a    = err_q[ax_q];
		add_b    = prod_sat;
		add_sub  = 1'b0;
		mul_a    = acc_q[ax_q];
		mul_b    = inv_ti_q[ax_q];
		load_out = 1'b0;
		s_axis_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid)
					state_d = ST_ERR;
			end
			ST_ERR: begin
				add_a   = ref_q[ax_q];
				add_b   = pos_q[ax_q];
				add_sub = 1'b1;
				state_d = ST_MUL_I;
			end
			ST_MUL_I: begin
				state_d = ST_SUM;
			end
			ST_SUM: begin
				state_d = ST_MUL_P;
			end
			ST_MUL_P: begin
				mul_a   = sum_q;
				mul_b   = gain_q[ax_q];
				state_d = ST_VEL;
			end
			ST_VEL: begin
				add_a   = ff_q[ax_q];
				state_d = ST_MUL_T;
			end
			ST_MUL_T: begin
				mul_a   = err_q[ax_q];
				mul_b   = ts_q;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				add_a   = acc_q[ax_q];
				state_d = ax_q ? ST_OUT : ST_ERR;
			end
			ST_OUT: begin
				// wait until the previous result has been taken
				if (!out_valid_q || m_axis_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign add_wide = add_sub ? ({add_a[DATA_WIDTH-1], add_a} - {add_b[DATA_WIDTH-1], add_b})
	                          : ({add_a[DATA_WIDTH-1], add_a} + {add_b[DATA_WIDTH-1], add_b});
	assign add_res  = sat_sum(add_wide);
	assign mul_res  = $signed({mul_a[DATA_WIDTH-1], mul_a}) * $signed({1'b0, mul_b});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q        <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q[0]    <= '0;
			acc_q[1]    <= '0;
			gain_q[0]   <= GAIN_RST;
			gain_q[1]   <= GAIN_RST;
			inv_ti_q[0] <= INV_RST;
			inv_ti_q[1] <= INV_RST;
			ts_q        <= TS_RST;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_addr))
					CFG_GAIN_X:      gain_q[0]   <= cfg_data;
					CFG_GAIN_Y:      gain_q[1]   <= cfg_data;
					CFG_INV_TI_X:    inv_ti_q[0] <= cfg_data;
					CFG_INV_TI_Y:    inv_ti_q[1] <= cfg_data;
					CFG_SAMPLE_TIME: ts_q        <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_IDLE)
				ax_q <= 1'b0;
			else if (state_q == ST_ACC)
				ax_q <= ~ax_q;
			// integral advances after the velocity term used the old value
			if (state_q == ST_ACC)
				acc_q[ax_q] <= add_res;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			ref_q[0] <= s_axis_tdata[0*DATA_WIDTH +: DATA_WIDTH];
			ref_q[1] <= s_axis_tdata[1*DATA_WIDTH +: DATA_WIDTH];
			pos_q[0] <= s_axis_tdata[2*DATA_WIDTH +: DATA_WIDTH];
			pos_q[1] <= s_axis_tdata[3*DATA_WIDTH +: DATA_WIDTH];
			ff_q[0]  <= s_axis_tdata[4*DATA_WIDTH +: DATA_WIDTH];
			ff_q[1]  <= s_axis_tdata[5*DATA_WIDTH +: DATA_WIDTH];
		end
		if (state_q == ST_MUL_I || state_q == ST_MUL_P || state_q == ST_MUL_T)
			prod_q <= mul_res;
		if (state_q == ST_ERR)
			err_q[ax_q] <= add_res;
		if (state_q == ST_SUM)
			sum_q <= add_res;
		if (state_q == ST_VEL)
			vel_q[ax_q] <= add_res;
		if (load_out)
			out_data_q <= {acc_q[1], acc_q[0], err_q[1], err_q[0], vel_q[1], vel_q[0]};
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ===== verif/pi_tick_check_pkg.sv =====
// Request/result layouts and the scoreboard for the two-axis PI controller bench.
// Depends on tapfc_pkg for widths, register indexes and reset values; used by tb_top.
`timescale 1ns / 100ps
package pi_tick_check_pkg;
	import tapfc_pkg::*;

	localparam int WIDE_W = 2 * DATA_WIDTH + 2;

	typedef logic signed [DATA_WIDTH-1:0] q_t;
	typedef logic [DATA_WIDTH-1:0]        ureg_t;
	typedef logic signed [WIDE_W-1:0]     wide_t;

	// last listed field (ref_x) in the lowest bits
	typedef struct packed {
		q_t ff_y, ff_x, pos_y, pos_x, ref_y, ref_x;
	} tick_req_t;

	typedef struct packed {
		q_t int_y, int_x, err_y, err_x, vel_y, vel_x;
	} tick_res_t;

	class pi_tick_scoreboard;
		ureg_t gain_x, gain_y, inv_ti_x, inv_ti_y, sample_time;
		q_t integ_x, integ_y;
		tick_res_t expected_cmds[$];
		int errors;
		int results_seen;

		function new();
			gain_x = GAIN_RST;
			gain_y = GAIN_RST;
			inv_ti_x = INV_RST;
			inv_ti_y = INV_RST;
			sample_time = TS_RST;
			integ_x = '0;
			integ_y = '0;
			errors = 0;
			results_seen = 0;
		endfunction

		function void write_reg(input logic [CFG_AW-1:0] idx, input ureg_t val);
			case (idx)
				CFG_GAIN_X:      gain_x = val;
				CFG_GAIN_Y:      gain_y = val;
				CFG_INV_TI_X:    inv_ti_x = val;
				CFG_INV_TI_Y:    inv_ti_y = val;
				CFG_SAMPLE_TIME: sample_time = val;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_cmds.size();
		endfunction

		static function wide_t widen(input q_t v);
			return v;
		endfunction

		static function q_t clamp(input wide_t v);
			if (v > widen(SMAX))
				return SMAX;
			if (v < widen(SMIN))
				return SMIN;
			return v[DATA_WIDTH-1:0];
		endfunction

		static function q_t add_q(input q_t a, input q_t b);
			return clamp(widen(a) + widen(b));
		endfunction

		static function q_t sub_q(input q_t a, input q_t b);
			return clamp(widen(a) - widen(b));
		endfunction

		// exact product, arithmetic shift gives floor, then clamp
		static function q_t mul_qu(input q_t a, input ureg_t u);
			wide_t p;
			p = widen(a) * $signed({{(WIDE_W - DATA_WIDTH){1'b0}}, u});
			return clamp(p >>> FRAC_BITS);
		endfunction

		// one axis: error, velocity from the old integral, then forward Euler update
		function void axis_step(input q_t r, p, ff, input ureg_t g, inv,
			inout q_t integ, output q_t vel, err);
			q_t e, s;
			e = sub_q(r, p);
			s = add_q(e, mul_qu(integ, inv));
			vel = add_q(ff, mul_qu(s, g));
			err = e;
			integ = add_q(integ, mul_qu(e, sample_time));
		endfunction

		function void note_request(input tick_req_t req);
			tick_res_t res;
			q_t vx, vy, ex, ey;
			axis_step(req.ref_x, req.pos_x, req.ff_x, gain_x, inv_ti_x, integ_x, vx, ex);
			axis_step(req.ref_y, req.pos_y, req.ff_y, gain_y, inv_ti_y, integ_y, vy, ey);
			res.vel_x = vx;
			res.vel_y = vy;
			res.err_x = ex;
			res.err_y = ey;
			res.int_x = integ_x;
			res.int_y = integ_y;
			expected_cmds = {expected_cmds, res};
		endfunction

		task report_mismatch(input string what);
			errors++;
			$display("MISMATCH result %0d: %s", results_seen, what);
		endtask

		task compare_field(input string name, input q_t got, input q_t want);
			if (got !== want)
				report_mismatch($sformatf("%s got %h expected %h", name, got, want));
		endtask

		task check_result(input logic [TDATA_W-1:0] data);
			tick_res_t got, want;
			got = data;
			results_seen++;
			if (expected_cmds.size() == 0) begin
				report_mismatch("result with nothing expected");
				return;
			end
			want = expected_cmds.pop_front();
			compare_field("vel_x", got.vel_x, want.vel_x);
			compare_field("vel_y", got.vel_y, want.vel_y);
			compare_field("err_x", got.err_x, want.err_x);
			compare_field("err_y", got.err_y, want.err_y);
			compare_field("int_x_out", got.int_x, want.int_x);
			compare_field("int_y_out", got.int_y, want.int_y);
		endtask
	endclass

endpackage

// ===== verif/tb_top.sv =====
// Top-level bench for two_axis_pi_feedforward_controller: stream driver, result
// monitor, config writer and watchdog. Depends on tapfc_pkg and pi_tick_check_pkg.
`timescale 1ns / 100ps
module tb_top;
	import tapfc_pkg::*;
	import pi_tick_check_pkg::*;

	localparam int BLOCK_ITEMS  = 70;    // requests between config changes
	localparam int BLOCKS       = 5;     // per idling mode, three modes
	localparam int HOLD_CYCLES  = 300;   // long receiver stall
	localparam int STALL_LIMIT  = 3000;  // cycles with no request moving
	localparam int DRAIN_CYCLES = 24;    // extra idle cycles after the final settle
	localparam int SMALL_SPAN   = 1 << 18;
	localparam logic [CFG_AW-1:0] CFG_UNUSED = CFG_AW'(CFG_SAMPLE_TIME + 1);

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_AW-1:0]     cfg_addr = '0;
	logic [DATA_WIDTH-1:0] cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [TDATA_W-1:0]    s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [TDATA_W-1:0]    m_axis_tdata;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_req = 0;     // bumped by the stimulus to ask for a long stall
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	pi_tick_scoreboard sb;

	always #5 clk = ~clk;

	two_axis_pi_feedforward_controller DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Result side: checks on the edge's sampled values, then picks next tready.
	// The long hold-off is counted here so the sender keeps pushing meanwhile.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Watchdog: any request moving on either side restarts the count
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Field values: extremes, full-range noise, and mostly values near zero
	function automatic q_t rand_field();
		case ($urandom_range(0, 7))
			0: return SMAX;
			1: return SMIN;
			2, 3: return q_t'($urandom);
			default: return q_t'(int'($urandom_range(0, 2 * SMALL_SPAN)) - SMALL_SPAN);
		endcase
	endfunction

	// Measured position usually tracks the reference, so errors stay moderate
	function automatic q_t near(input q_t target);
		if ($urandom_range(0, 9) == 0)
			return rand_field();
		return target + q_t'(int'($urandom_range(0, 2 * SMALL_SPAN)) - SMALL_SPAN);
	endfunction

	function automatic tick_req_t rand_tick();
		tick_req_t r;
		r.ref_x = rand_field();
		r.ref_y = rand_field();
		r.pos_x = near(r.ref_x);
		r.pos_y = near(r.ref_y);
		r.ff_x = rand_field();
		r.ff_y = rand_field();
		return r;
	endfunction

	function automatic tick_req_t mk_tick(input q_t rx, ry, px, py, fx, fy);
		tick_req_t r;
		r.ref_x = rx;
		r.ref_y = ry;
		r.pos_x = px;
		r.pos_y = py;
		r.ff_x = fx;
		r.ff_y = fy;
		return r;
	endfunction

	// Register values: zero, all ones, full noise, or a moderate gain (up to 4.0)
	function automatic ureg_t rand_reg();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return ureg_t'($urandom);
			default: return ureg_t'($urandom_range(0, 4 << FRAC_BITS));
		endcase
	endfunction

	// Offer one request, hold it until taken, then maybe idle a few cycles.
	// tvalid stays high across back-to-back requests.
	task automatic send_tick(input tick_req_t r);
		int gap;
		s_axis_tdata <= r;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_request(r);
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every expected result has been taken
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_AW-1:0] idx, input ureg_t val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	// Config only changes with the block drained. A write to an unused
	// index rides along each time and must leave every register alone.
	task automatic program_regs(input ureg_t gx, gy, itx, ity, ts);
		settle();
		put_reg(CFG_GAIN_X, gx);
		put_reg(CFG_GAIN_Y, gy);
		put_reg(CFG_INV_TI_X, itx);
		put_reg(CFG_INV_TI_Y, ity);
		put_reg(CFG_SAMPLE_TIME, ts);
		put_reg(CFG_AW'($urandom_range(CFG_UNUSED, (1 << CFG_AW) - 1)), ureg_t'($urandom));
		cfg_we <= 1'b0;
	endtask

	initial begin
		sb = new();
		send_idle_pct = 33;
		recv_idle_pct = 45;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset config: gain 1.0, integral off, Ts about 0.01
		send_tick(mk_tick('0, '0, '0, '0, '0, '0));
		// error saturates high on x, low on y
		send_tick(mk_tick(SMAX, SMIN, SMIN, SMAX, '0, '0));
		// feedforward drives the velocity into the clamp
		send_tick(mk_tick(SMAX, SMIN, SMIN, SMAX, SMAX, SMIN));
		send_tick(mk_tick(SMIN, SMAX, SMAX, SMIN, SMIN, SMAX));
		send_tick(mk_tick(q_t'(32'h5555_5555), q_t'(32'hAAAA_AAAA), q_t'(32'hAAAA_AAAA),
			q_t'(32'h5555_5555), q_t'(32'h0F0F_0F0F), q_t'(32'hF0F0_F0F0)));
		send_tick(mk_tick(q_t'(1), q_t'(-1), '0, '0, '0, '0));

		// All registers at max: large products clamp; negative products floor toward minus infinity
		program_regs('1, '1, '1, '1, '1);
		send_tick(mk_tick(q_t'(1), q_t'(-1), '0, '0, '0, '0));
		send_tick(mk_tick(q_t'(-1), q_t'(1), '0, '0, '0, '0));
		send_tick(mk_tick('0, '0, q_t'(1 << FRAC_BITS), q_t'(-(1 << FRAC_BITS)), SMAX, SMIN));

		// All zero: no P, no I, integral frozen; velocity is just feedforward
		program_regs('0, '0, '0, '0, '0);
		send_tick(mk_tick(SMAX, SMIN, '0, '0, q_t'(12345), q_t'(-12345)));
		send_tick(rand_tick());
		send_tick(rand_tick());

		// Unity gain, 1/Ti and Ts: the integral sums raw error,
		// then one opposite full-scale error swings it across zero
		program_regs(ureg_t'(1 << FRAC_BITS), ureg_t'(1 << FRAC_BITS),
			ureg_t'(1 << FRAC_BITS), ureg_t'(1 << FRAC_BITS), ureg_t'(1 << FRAC_BITS));
		repeat (4) send_tick(mk_tick(q_t'(32'h3000_0000), q_t'(32'hD000_0000), '0, '0, '0, '0));
		send_tick(mk_tick(SMIN, SMAX, '0, '0, '0, '0));

		// Random traffic under three idling mixes, new config every block
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = 33;
					recv_idle_pct = 45;
				end
				1: begin
					send_idle_pct = 45;
					recv_idle_pct = 33;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int blk = 0; blk < BLOCKS; blk++) begin
				program_regs(rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg());
				// long result stall while requests keep coming: input must back up
				if (blk == 1)
					hold_req++;
				repeat (BLOCK_ITEMS) send_tick(rand_tick());
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
